// ===== rtl/pidsc_pkg.sv =====
package pidsc_pkg;

  // Field widths
  localparam int OP_W     = 3;
  localparam int SPEED_W  = 16;
  localparam int ERR_W    = 17;
  localparam int DIFF_W   = 18;
  localparam int TIME_W   = 32;
  localparam int PGAIN_W  = 24;
  localparam int KI_W     = 32;
  localparam int KD_W     = 32;
  localparam int SLOPE_W  = 32;
  localparam int DRIVE_W  = 32;

  // Slope is Q16 per microsecond
  localparam int SLOPE_FRAC = 16;

  // Operation codes
  localparam logic [OP_W-1:0] OP_PID    = 3'd0;
  localparam logic [OP_W-1:0] OP_PI_LAG = 3'd1;
  localparam logic [OP_W-1:0] OP_P_ONLY = 3'd2;
  localparam logic [OP_W-1:0] OP_PI     = 3'd3;
  localparam logic [OP_W-1:0] OP_RESET  = 3'd4;

  // Configuration port
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_W  = 2;
  localparam logic [REG_IDX_W-1:0] REG_PROP  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_INTEG = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_DERIV = 2'd2;

  // Shared multiplier: signed 33 x 33
  localparam int MUL_W  = 33;
  localparam int PROD_W = 2 * MUL_W;

  // Fixed-point alignment of each term
  localparam int P_SHIFT    = 12;
  localparam int IL_SHIFT   = 32;
  localparam int D_SHIFT    = 24;
  localparam int TRAP_SHIFT = 1;   // trapezoid: divide by 2

  // Trapezoid increment fits (18 + 33) bits signed
  localparam int INC_W = DIFF_W + MUL_W;

endpackage

// ===== rtl/pidsc_if.sv =====
interface pidsc_in_if
  import pidsc_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic        [OP_W-1:0]    op;
  logic signed [SPEED_W-1:0] target;
  logic signed [SPEED_W-1:0] measured;
  logic        [TIME_W-1:0]  now_us;
  logic signed [PGAIN_W-1:0] p_gain;

  modport source (output valid, op, target, measured, now_us, p_gain, input ready);
  modport sink   (input valid, op, target, measured, now_us, p_gain, output ready);
endinterface

interface pidsc_out_if
  import pidsc_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic signed [DRIVE_W-1:0] drive;

  modport source (output valid, drive, input ready);
  modport sink   (input valid, drive, output ready);
endinterface

// ===== rtl/pidsc_div.sv =====
// Restoring divider for the error slope: trunc(diff * 2^16 / dt), saturated
// to 32 signed bits. One quotient bit per cycle.
module pidsc_div
  import pidsc_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic signed [DIFF_W-1:0]  diff_i,
  input  logic        [TIME_W-1:0]  dt_i,
  output logic                      done_o,
  output logic signed [SLOPE_W-1:0] slope_o
);

  localparam int NUM_W = DIFF_W + SLOPE_FRAC;
  localparam int REM_W = TIME_W + 1;
  localparam int CNT_W = $clog2(NUM_W + 1);
  localparam logic [NUM_W-1:0] SLOPE_LIM = NUM_W'(1) << (SLOPE_W - 1);
  localparam logic [SLOPE_W-1:0] SLOPE_MAX = {1'b0, {(SLOPE_W-1){1'b1}}};
  localparam logic [SLOPE_W-1:0] SLOPE_MIN = {1'b1, {(SLOPE_W-1){1'b0}}};

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [NUM_W-1:0] quo_q, quo_d;
  logic [REM_W-1:0] rem_q, rem_d;
  logic [TIME_W-1:0] den_q, den_d;
  logic             neg_q, neg_d;

  logic [DIFF_W-1:0] mag;
  logic [REM_W-1:0]  rem_sh;
  logic [REM_W:0]    trial;
  logic              fits;

  assign mag    = diff_i[DIFF_W-1] ? DIFF_W'(-diff_i) : DIFF_W'(diff_i);
  assign rem_sh = {rem_q[REM_W-2:0], quo_q[NUM_W-1]};
  assign trial  = {1'b0, rem_sh} - {2'b00, den_q};
  assign fits   = !trial[REM_W];

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    neg_d  = neg_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(NUM_W);
      quo_d  = {mag, {SLOPE_FRAC{1'b0}}};
      rem_d  = '0;
      den_d  = dt_i;
      neg_d  = diff_i[DIFF_W-1];
    end else if (busy_q) begin
      rem_d = fits ? trial[REM_W-1:0] : rem_sh;
      quo_d = {quo_q[NUM_W-2:0], fits};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
    neg_q <= neg_d;
  end

  // Saturate the signed quotient to 32 bits
  always_comb begin
    if (!neg_q) begin
      slope_o = (quo_q >= SLOPE_LIM) ? SLOPE_MAX : quo_q[SLOPE_W-1:0];
    end else begin
      slope_o = (quo_q > SLOPE_LIM) ? SLOPE_MIN : -quo_q[SLOPE_W-1:0];
    end
  end

  assign done_o = done_q;

endmodule

// ===== rtl/pid_speed_controller.sv =====
// PID speed controller, fixed point. Each input transaction carries an
// operation code, a target and a measured speed (signed rpm), a free-running
// microsecond timestamp and a per-transaction P gain; each one yields exactly
// one output transaction with a 32-bit saturated drive value. Op 0 runs full
// PID with a trapezoidal integral and the error slope over elapsed time, op 1
// runs PI plus the slope stored by the previous op 1, op 2 is P only with the
// transaction's own gain, op 3 is PI, op 4 clears the integral and reloads the
// previous error and time (drive 0); codes 5..7 return 0 and change nothing.
// Gains sit in an APB register file: prop_gain (Q12.12) at 0x0, integ_gain
// (Q0.32) at 0x4, deriv_gain (Q24.8) at 0x8; write them only while idle.
// The block works on one transaction at a time: one signed 33x33 multiplier
// is reused for the integral increment and for the P, I and D terms, and a
// 34-step restoring divider forms the slope. A new transaction is taken
// only after the previous one has run its steps (the divider only for ops 0
// and 1 with nonzero elapsed time, no multiplier for ops 4 to 7) and has
// moved its result into the output register once that register is free.
// A finished result waits in the output register
// while the next transaction is taken. The integral is INTEG_BITS wide.
module pid_speed_controller
  import pidsc_pkg::*;
#(
  parameter int unsigned INTEG_BITS = 48
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  pidsc_in_if.sink              in_if,
  pidsc_out_if.source           out_if,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  typedef enum logic [3:0] {
    S_IDLE, S_INC_MUL, S_INC_ADD, S_DIV, S_P_MUL,
    S_IL_MUL, S_IH_MUL, S_D_MUL, S_FLUSH, S_OUT
  } state_e;

  // Which term the product register holds, so the next cycle can align it
  typedef enum logic [2:0] {TERM_NONE, TERM_P, TERM_IL, TERM_IH, TERM_D} term_e;

  localparam int ACC_SUM_W = ((INTEG_BITS > INC_W) ? INTEG_BITS : INC_W) + 1;
  localparam logic signed [ACC_SUM_W-1:0] ACC_MAX =
      (ACC_SUM_W'(1) <<< (INTEG_BITS - 1)) - ACC_SUM_W'(1);
  localparam logic signed [ACC_SUM_W-1:0] ACC_MIN = ~ACC_MAX;
  localparam logic signed [PROD_W-1:0] DRV_MAX =
      (PROD_W'(1) <<< (DRIVE_W - 1)) - PROD_W'(1);
  localparam logic signed [PROD_W-1:0] DRV_MIN = ~DRV_MAX;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic signed [PGAIN_W-1:0] kp_q;
  logic signed [KI_W-1:0]    ki_q;
  logic signed [KD_W-1:0]    kd_q;
  logic                      cfg_wr;
  logic [REG_IDX_W-1:0]      cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[APB_ADDR_W-1:APB_ADDR_W-REG_IDX_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q <= '0;
      ki_q <= '0;
      kd_q <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_PROP:  kp_q <= pwdata[PGAIN_W-1:0];
        REG_INTEG: ki_q <= pwdata[KI_W-1:0];
        REG_DERIV: kd_q <= pwdata[KD_W-1:0];
        default:   ;  // hole in the map: drop the write
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_PROP:  prdata = {{(APB_DATA_W-PGAIN_W){1'b0}}, kp_q};
      REG_INTEG: prdata = ki_q;
      REG_DERIV: prdata = kd_q;
      default:   prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  state_e                       state_q, state_d;
  term_e                        pend_q, pend_d;
  logic                         out_valid_q, out_valid_d;
  logic signed [DRIVE_W-1:0]    out_drive_q, out_drive_d;
  logic signed [INTEG_BITS-1:0] integ_q, integ_d;
  logic signed [ERR_W-1:0]      last_err_q, last_err_d;
  logic        [TIME_W-1:0]     last_time_q, last_time_d;
  logic signed [SLOPE_W-1:0]    lag_q, lag_d;

  // Per-transaction working registers (no reset needed)
  logic        [OP_W-1:0]    op_q, op_d;
  logic signed [SPEED_W-1:0] tgt_q, tgt_d;
  logic signed [ERR_W-1:0]   err_q, err_d;
  logic        [TIME_W-1:0]  now_q, now_d;
  logic signed [PGAIN_W-1:0] pg_q, pg_d;
  logic        [TIME_W-1:0]  dt_q, dt_d;
  logic signed [DIFF_W-1:0]  sum_q, sum_d;
  logic signed [DIFF_W-1:0]  diff_q, diff_d;
  logic signed [SLOPE_W-1:0] slope_q, slope_d;
  logic signed [PROD_W-1:0]  prod_q, prod_d;
  logic signed [PROD_W-1:0]  drv_q, drv_d;

  // ---------------------------------------------------------------------------
  // Slope divider
  // ---------------------------------------------------------------------------
  logic                      div_start;
  logic                      div_done;
  logic signed [SLOPE_W-1:0] div_slope;
  logic                      want_d;

  assign want_d    = (op_q == OP_PID) || (op_q == OP_PI_LAG);
  assign div_start = (state_q == S_INC_ADD) && want_d && (dt_q != '0);

  pidsc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .diff_i  (diff_q),
    .dt_i    (dt_q),
    .done_o  (div_done),
    .slope_o (div_slope)
  );

  // ---------------------------------------------------------------------------
  // Shared multiplier: operands picked by the sequencer, product registered
  // ---------------------------------------------------------------------------
  logic signed [MUL_W-1:0]   mul_a, mul_b;
  logic signed [63:0]        acc_ext;
  logic signed [SLOPE_W-1:0] d_slope;

  assign acc_ext = 64'(integ_q);
  assign d_slope = (op_q == OP_PID) ? slope_q : lag_q;

  always_comb begin
    case (state_q)
      S_INC_MUL: begin
        mul_a = MUL_W'(sum_q);
        mul_b = {1'b0, dt_q};
      end
      S_P_MUL: begin
        mul_a = MUL_W'((op_q == OP_P_ONLY) ? pg_q : kp_q);
        mul_b = MUL_W'(err_q);
      end
      S_IL_MUL: begin
        mul_a = MUL_W'(ki_q);
        mul_b = {1'b0, acc_ext[31:0]};
      end
      S_IH_MUL: begin
        mul_a = MUL_W'(ki_q);
        mul_b = MUL_W'(signed'(acc_ext[63:32]));
      end
      S_D_MUL: begin
        mul_a = MUL_W'(kd_q);
        mul_b = MUL_W'(d_slope);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_d = mul_a * mul_b;

  // Align the held product as a drive term (floor by arithmetic shift)
  logic signed [PROD_W-1:0] term;

  always_comb begin
    case (pend_q)
      TERM_P:  term = prod_q >>> P_SHIFT;
      TERM_IL: term = prod_q >>> IL_SHIFT;
      TERM_IH: term = prod_q;
      TERM_D:  term = prod_q >>> D_SHIFT;
      default: term = '0;
    endcase
  end

  // Trapezoid increment and saturating integral update
  logic signed [PROD_W-1:0]     inc_full;
  logic signed [ACC_SUM_W-1:0]  acc_sum;
  logic signed [INTEG_BITS-1:0] acc_sat;

  assign inc_full = prod_q >>> TRAP_SHIFT;
  assign acc_sum  = ACC_SUM_W'(integ_q) + ACC_SUM_W'(inc_full);

  always_comb begin
    if (acc_sum > ACC_MAX) begin
      acc_sat = INTEG_BITS'(ACC_MAX);
    end else if (acc_sum < ACC_MIN) begin
      acc_sat = INTEG_BITS'(ACC_MIN);
    end else begin
      acc_sat = INTEG_BITS'(acc_sum);
    end
  end

  // Drive saturation
  logic signed [DRIVE_W-1:0] drv_sat;

  always_comb begin
    if (drv_q > DRV_MAX) begin
      drv_sat = DRIVE_W'(DRV_MAX);
    end else if (drv_q < DRV_MIN) begin
      drv_sat = DRIVE_W'(DRV_MIN);
    end else begin
      drv_sat = DRIVE_W'(drv_q);
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  logic                    in_take;
  logic signed [ERR_W-1:0] err_in;

  assign in_if.ready = (state_q == S_IDLE);
  assign in_take     = in_if.valid && in_if.ready;
  assign err_in      = ERR_W'(in_if.target) - ERR_W'(in_if.measured);

  always_comb begin
    state_d     = state_q;
    pend_d      = TERM_NONE;
    out_valid_d = out_valid_q && !out_if.ready;
    out_drive_d = out_drive_q;
    integ_d     = integ_q;
    last_err_d  = last_err_q;
    last_time_d = last_time_q;
    lag_d       = lag_q;

    op_d    = op_q;
    tgt_d   = tgt_q;
    err_d   = err_q;
    now_d   = now_q;
    pg_d    = pg_q;
    dt_d    = dt_q;
    sum_d   = sum_q;
    diff_d  = diff_q;
    slope_d = slope_q;
    drv_d   = drv_q + term;

    case (state_q)
      S_IDLE: begin
        if (in_take) begin
          // Capture the transaction and form the error terms
          op_d   = in_if.op;
          tgt_d  = in_if.target;
          err_d  = err_in;
          now_d  = in_if.now_us;
          pg_d   = in_if.p_gain;
          dt_d   = in_if.now_us - last_time_q;
          sum_d  = DIFF_W'(err_in) + DIFF_W'(last_err_q);
          diff_d = DIFF_W'(err_in) - DIFF_W'(last_err_q);
          drv_d  = '0;
          case (in_if.op)
            OP_PID, OP_PI_LAG, OP_PI: state_d = S_INC_MUL;
            OP_P_ONLY:                state_d = S_P_MUL;
            default:                  state_d = S_FLUSH;
          endcase
        end
      end
      S_INC_MUL: state_d = S_INC_ADD;
      S_INC_ADD: begin
        integ_d = acc_sat;
        slope_d = '0;  // zero elapsed time: slope stays zero
        state_d = div_start ? S_DIV : S_P_MUL;
      end
      S_DIV: begin
        if (div_done) begin
          slope_d = div_slope;
          state_d = S_P_MUL;
        end
      end
      S_P_MUL: begin
        pend_d  = TERM_P;
        state_d = (op_q == OP_P_ONLY) ? S_FLUSH : S_IL_MUL;
      end
      S_IL_MUL: begin
        pend_d  = TERM_IL;
        state_d = S_IH_MUL;
      end
      S_IH_MUL: begin
        pend_d  = TERM_IH;
        state_d = want_d ? S_D_MUL : S_FLUSH;
      end
      S_D_MUL: begin
        pend_d  = TERM_D;
        state_d = S_FLUSH;
      end
      S_FLUSH: begin
        // Last term lands in drv this cycle; commit controller state
        case (op_q)
          OP_PID, OP_PI: begin
            last_err_d  = err_q;
            last_time_d = now_q;
          end
          OP_PI_LAG: begin
            last_err_d  = err_q;
            last_time_d = now_q;
            lag_d       = slope_q;
          end
          OP_RESET: begin
            integ_d     = '0;
            last_err_d  = ERR_W'(tgt_q);
            last_time_d = now_q;
          end
          default: ;
        endcase
        state_d = S_OUT;
      end
      S_OUT: begin
        // Hold until the output register is free
        if (!out_valid_q || out_if.ready) begin
          out_valid_d = 1'b1;
          out_drive_d = drv_sat;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pend_q      <= TERM_NONE;
      out_valid_q <= 1'b0;
      out_drive_q <= '0;
      integ_q     <= '0;
      last_err_q  <= '0;
      last_time_q <= '0;
      lag_q       <= '0;
    end else begin
      state_q     <= state_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
      out_drive_q <= out_drive_d;
      integ_q     <= integ_d;
      last_err_q  <= last_err_d;
      last_time_q <= last_time_d;
      lag_q       <= lag_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    tgt_q   <= tgt_d;
    err_q   <= err_d;
    now_q   <= now_d;
    pg_q    <= pg_d;
    dt_q    <= dt_d;
    sum_q   <= sum_d;
    diff_q  <= diff_d;
    slope_q <= slope_d;
    prod_q  <= prod_d;
    drv_q   <= drv_d;
  end

  assign out_if.valid = out_valid_q;
  assign out_if.drive = out_drive_q;

endmodule

// ===== rtl/pidsc_checker.sv =====
module pidsc_checker
  import pidsc_pkg::*;
(
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_i,
  input logic                      out_valid_i,
  input logic                      out_ready_i,
  input logic signed [DRIVE_W-1:0] out_drive_i
);

  // Busy after taking a transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input taken while previous transaction in flight");

  // A result only shows up after the block was busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      $rose(out_valid_i) |-> $past(!in_ready_i))
    else $error("result appeared without work");

  // Idle with nothing offered and nothing pending: no result invented
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      in_ready_i && !in_valid_i && !out_valid_i |=> !out_valid_i)
    else $error("spurious result");

  // Stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_drive_i))
    else $error("stalled result dropped or changed");

endmodule

bind pid_speed_controller pidsc_checker u_pidsc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_if.valid),
  .in_ready_i  (in_if.ready),
  .out_valid_i (out_if.valid),
  .out_ready_i (out_if.ready),
  .out_drive_i (out_if.drive)
);
